// ===== sv/intrinsic_edge_flip_test_top_defines.svh =====
// Assertion macros used by the checker file of the edge flip test block.
`ifndef INTRINSIC_EDGE_FLIP_TEST_TOP_DEFINES_SVH
`define INTRINSIC_EDGE_FLIP_TEST_TOP_DEFINES_SVH

// Property that is checked only outside reset.
`define IEFT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property that is checked at every edge, reset included.
`define IEFT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ieft_pkg.sv =====
package ieft_pkg;

   localparam int LEN_W    = 32;
   localparam int LIMB_W   = 34;
   localparam int LIMBS    = 4;
   localparam int MUL_W    = LIMB_W * LIMBS;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ROOT_W   = PROD_W / 2;
   localparam int MUL_LAT  = 4;
   localparam int SQRT_LAT = ROOT_W;
   localparam int DIV_LAT  = LEN_W;

   typedef struct packed {
      logic [LEN_W-1:0] shared_length;
      logic [LEN_W-1:0] first_next_length;
      logic [LEN_W-1:0] first_prev_length;
      logic [LEN_W-1:0] second_next_length;
      logic [LEN_W-1:0] second_prev_length;
   } req_type;

   typedef struct packed {
      logic             needs_flip;
      logic             degenerate;
      logic [LEN_W-1:0] flipped_length;
   } rsp_type;

endpackage

// ===== sv/intrinsic_edge_flip_test_top.sv =====
// Throughput: one quad per cycle; the whole pipeline advances together, so a stall holds it.
// The pipeline is built from two 136-stage square root pipelines, two rounds of 4-stage
// multipliers and a 32-stage divider.
// Reset is synchronous and active high; it clears every stage valid bit and the
// result valid, and the block takes a transfer in the first cycle after reset.
module intrinsic_edge_flip_test_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ieft_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ieft_pkg::rsp_type rsp_data
);
   import ieft_pkg::*;

   // Widths of the intermediate quantities. Heron factors need two guard bits,
   // signed numerators three above a square.
   localparam int FAC_W = LEN_W + 2;
   localparam int SQ_W  = 2 * LEN_W;
   localparam int FP_W  = 2 * FAC_W;
   localparam int NUM_W = SQ_W + 3;
   localparam int MAG_W = NUM_W - 1;
   localparam int QP_W  = ROOT_W + 2;
   localparam int Q_W   = ROOT_W + 3;
   localparam int R2_W  = (Q_W + 1) / 2;
   localparam int DV_W  = LEN_W + 1;

   // Multiplier slots of the two rounds.
   localparam int R1_MULS = 5;
   localparam int MUL_H0  = 0;
   localparam int MUL_H1  = 1;
   localparam int MUL_N0  = 2;
   localparam int MUL_N1  = 3;
   localparam int MUL_D   = 4;
   localparam int R2_MULS = 3;
   localparam int MUL_HH  = 0;
   localparam int MUL_X   = 1;
   localparam int MUL_Y   = 2;

   typedef struct packed {
      logic                             valid;
      logic                             degen;
      logic [LEN_W-1:0]                 len;
      logic [4:0][SQ_W-1:0]             sq;
      logic [1:0][3:0][FAC_W-1:0]       fac;
   } a_type;

   typedef struct packed {
      logic                  valid;
      logic                  degen;
      logic [LEN_W-1:0]      len;
      logic [3:0][FP_W-1:0]  fp;
      logic [2:0][NUM_W-1:0] num;
   } b_type;

   typedef struct packed {
      logic                  valid;
      logic                  degen;
      logic [LEN_W-1:0]      len;
      logic [3:0][FP_W-1:0]  fp;
      logic [2:0][MAG_W-1:0] mag;
      logic                  n0neg;
      logic                  n1neg;
   } c_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [LEN_W-1:0] len;
      logic             n0neg;
      logic             n1neg;
   } r1_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [LEN_W-1:0] len;
      logic             n0neg;
      logic             n1neg;
      logic [QP_W-1:0]  qpart;
   } r2_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [LEN_W-1:0] len;
      logic             flip;
      logic [QP_W-1:0]  qpart;
   } s3_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [LEN_W-1:0] len;
      logic             flip;
      logic [Q_W-1:0]   q;
   } f_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic [LEN_W-1:0] len;
      logic             flip;
   } s4_type;

   typedef struct packed {
      logic             valid;
      logic             degen;
      logic             flip;
      logic             sat;
      logic [DV_W-1:0]  dv;
      logic [R2_W-1:0]  rem;
      logic [LEN_W-1:0] quo;
   } d_type;

   // The four Heron factors of one triangle, two's complement with a sign bit.
   // Index zero is the perimeter; the other three are the triangle inequalities.
   function automatic logic [3:0][FAC_W:0] heron_factors(
      input logic [LEN_W-1:0] a,
      input logic [LEN_W-1:0] b,
      input logic [LEN_W-1:0] c
   );
      logic [3:0][FAC_W:0] f;
      logic [FAC_W:0]      ea, eb, ec;
      ea   = (FAC_W+1)'(a);
      eb   = (FAC_W+1)'(b);
      ec   = (FAC_W+1)'(c);
      f[0] = ea + eb + ec;
      f[1] = eb + ec - ea;
      f[2] = ea + ec - eb;
      f[3] = ea + eb - ec;
      return f;
   endfunction

   // A triangle has area only when all three inequality factors are positive.
   function automatic logic is_strict(input logic [3:0][FAC_W:0] f);
      return !f[1][FAC_W] && (f[1] != '0) && !f[2][FAC_W] && (f[2] != '0) &&
             !f[3][FAC_W] && (f[3] != '0);
   endfunction

   // One restoring quotient step for quotient bit position pos.
   function automatic d_type div_step(input d_type d, input int pos);
      d_type           r;
      logic [R2_W-1:0] shifted;
      r       = d;
      shifted = R2_W'(d.dv) << pos;
      if (d.rem >= shifted) begin
         r.rem = d.rem - shifted;
         r.quo = {d.quo[LEN_W-2:0], 1'b1};
      end else begin
         r.quo = {d.quo[LEN_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // The whole pipeline moves as one: it advances whenever the result register
   // is empty or its transfer completes in this cycle.
   logic adv;

   a_type  a_in, a_ff;
   b_type  b_in, b_ff;
   c_type  c_in, c_ff;
   r1_type r1_ff [MUL_LAT];
   r2_type r2_in;
   r2_type r2_ff [MUL_LAT];
   s3_type s3_in;
   s3_type s3_ff [SQRT_LAT];
   f_type  f_in, f_ff;
   s4_type s4_ff [SQRT_LAT];
   d_type  d_seed;
   d_type  d_ff [DIV_LAT];
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_ff;

   logic [3:0][FAC_W:0] fac_first, fac_second;

   logic [MUL_W-1:0]  m1_a [R1_MULS];
   logic [MUL_W-1:0]  m1_b [R1_MULS];
   logic [PROD_W-1:0] m1_p [R1_MULS];
   logic [MUL_W-1:0]  m2_a [R2_MULS];
   logic [MUL_W-1:0]  m2_b [R2_MULS];
   logic [PROD_W-1:0] m2_p [R2_MULS];

   logic [ROOT_W-1:0] root_hh, root_q;
   logic              mixed_flip;

   // The input is closed while reset is high, since stage A drops anything offered then.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !reset;

   // Stage A: squares of the five lengths, Heron factors and the degenerate test.
   assign fac_first  = heron_factors(req_data.shared_length, req_data.first_next_length,
                                     req_data.first_prev_length);
   assign fac_second = heron_factors(req_data.shared_length, req_data.second_next_length,
                                     req_data.second_prev_length);

   always_comb begin
      a_in.valid = req_valid;
      a_in.degen = !(is_strict(fac_first) && is_strict(fac_second));
      a_in.len   = req_data.shared_length;
      a_in.sq[0] = SQ_W'(req_data.shared_length) * SQ_W'(req_data.shared_length);
      a_in.sq[1] = SQ_W'(req_data.first_next_length) * SQ_W'(req_data.first_next_length);
      a_in.sq[2] = SQ_W'(req_data.first_prev_length) * SQ_W'(req_data.first_prev_length);
      a_in.sq[3] = SQ_W'(req_data.second_next_length) * SQ_W'(req_data.second_next_length);
      a_in.sq[4] = SQ_W'(req_data.second_prev_length) * SQ_W'(req_data.second_prev_length);
      for (int i = 0; i < 4; i++) begin
         a_in.fac[0][i] = fac_first[i][FAC_W-1:0];
         a_in.fac[1][i] = fac_second[i][FAC_W-1:0];
      end
   end

   // Stage B: pairwise Heron products, the two cotangent numerators and the
   // difference of squares that unfolds the quad into the plane.
   always_comb begin
      b_in.valid  = a_ff.valid;
      b_in.degen  = a_ff.degen;
      b_in.len    = a_ff.len;
      b_in.fp[0]  = FP_W'(a_ff.fac[0][0]) * FP_W'(a_ff.fac[0][1]);
      b_in.fp[1]  = FP_W'(a_ff.fac[0][2]) * FP_W'(a_ff.fac[0][3]);
      b_in.fp[2]  = FP_W'(a_ff.fac[1][0]) * FP_W'(a_ff.fac[1][1]);
      b_in.fp[3]  = FP_W'(a_ff.fac[1][2]) * FP_W'(a_ff.fac[1][3]);
      b_in.num[0] = NUM_W'(a_ff.sq[1]) + NUM_W'(a_ff.sq[2]) - NUM_W'(a_ff.sq[0]);
      b_in.num[1] = NUM_W'(a_ff.sq[3]) + NUM_W'(a_ff.sq[4]) - NUM_W'(a_ff.sq[0]);
      b_in.num[2] = NUM_W'(a_ff.sq[2]) + NUM_W'(a_ff.sq[4]) - NUM_W'(a_ff.sq[1]) -
                    NUM_W'(a_ff.sq[3]);
   end

   // Stage C: magnitudes and signs, so the wide multipliers work unsigned.
   always_comb begin
      c_in.valid = b_ff.valid;
      c_in.degen = b_ff.degen;
      c_in.len   = b_ff.len;
      c_in.fp    = b_ff.fp;
      for (int i = 0; i < 3; i++) begin
         c_in.mag[i] = b_ff.num[i][NUM_W-1] ? MAG_W'(-b_ff.num[i]) : MAG_W'(b_ff.num[i]);
      end
      c_in.n0neg = b_ff.num[0][NUM_W-1];
      c_in.n1neg = b_ff.num[1][NUM_W-1];
   end

   // First multiplier round: both areas squared (times 16) and three squares.
   always_comb begin
      m1_a[MUL_H0] = MUL_W'(c_ff.fp[0]);
      m1_b[MUL_H0] = MUL_W'(c_ff.fp[1]);
      m1_a[MUL_H1] = MUL_W'(c_ff.fp[2]);
      m1_b[MUL_H1] = MUL_W'(c_ff.fp[3]);
      m1_a[MUL_N0] = MUL_W'(c_ff.mag[0]);
      m1_b[MUL_N0] = MUL_W'(c_ff.mag[0]);
      m1_a[MUL_N1] = MUL_W'(c_ff.mag[1]);
      m1_b[MUL_N1] = MUL_W'(c_ff.mag[1]);
      m1_a[MUL_D]  = MUL_W'(c_ff.mag[2]);
      m1_b[MUL_D]  = MUL_W'(c_ff.mag[2]);
   end

   for (genvar g = 0; g < R1_MULS; g++) begin : g_round1
      ieft_mul u_mul (
         .clock (clock),
         .en    (adv),
         .a     (m1_a[g]),
         .b     (m1_b[g]),
         .p     (m1_p[g])
      );
   end

   // Second round: the product of the areas for the cross root, and the two
   // cross terms that decide the sign of the cotangent sum when the numerators
   // disagree in sign. The partial diagonal sum enters the side line here.
   always_comb begin
      m2_a[MUL_HH] = m1_p[MUL_H0][MUL_W-1:0];
      m2_b[MUL_HH] = m1_p[MUL_H1][MUL_W-1:0];
      m2_a[MUL_X]  = m1_p[MUL_N1][MUL_W-1:0];
      m2_b[MUL_X]  = m1_p[MUL_H0][MUL_W-1:0];
      m2_a[MUL_Y]  = m1_p[MUL_N0][MUL_W-1:0];
      m2_b[MUL_Y]  = m1_p[MUL_H1][MUL_W-1:0];

      r2_in.valid = r1_ff[MUL_LAT-1].valid;
      r2_in.degen = r1_ff[MUL_LAT-1].degen;
      r2_in.len   = r1_ff[MUL_LAT-1].len;
      r2_in.n0neg = r1_ff[MUL_LAT-1].n0neg;
      r2_in.n1neg = r1_ff[MUL_LAT-1].n1neg;
      r2_in.qpart = QP_W'(m1_p[MUL_D]) + QP_W'(m1_p[MUL_H0]) + QP_W'(m1_p[MUL_H1]);
   end

   for (genvar g = 0; g < R2_MULS; g++) begin : g_round2
      ieft_mul u_mul (
         .clock (clock),
         .en    (adv),
         .a     (m2_a[g]),
         .b     (m2_b[g]),
         .p     (m2_p[g])
      );
   end

   // Flip decision. Both numerators negative means both cotangents are negative and the edge flips;
   // both non-negative means no flip. Otherwise the squared numerators weighted
   // by the other triangle's area tell which cotangent dominates. A sum of
   // exactly zero compares equal and does not flip.
   always_comb begin
      if (r2_ff[MUL_LAT-1].n0neg) begin
         mixed_flip = m2_p[MUL_X] < m2_p[MUL_Y];
      end else begin
         mixed_flip = m2_p[MUL_Y] < m2_p[MUL_X];
      end
      s3_in.valid = r2_ff[MUL_LAT-1].valid;
      s3_in.degen = r2_ff[MUL_LAT-1].degen;
      s3_in.len   = r2_ff[MUL_LAT-1].len;
      s3_in.qpart = r2_ff[MUL_LAT-1].qpart;
      s3_in.flip  = (r2_ff[MUL_LAT-1].n0neg && r2_ff[MUL_LAT-1].n1neg) ||
                    ((r2_ff[MUL_LAT-1].n0neg != r2_ff[MUL_LAT-1].n1neg) && mixed_flip);
   end

   // Floor square root of the area product, one root bit per stage.
   ieft_isqrt u_isqrt_cross (
      .clock    (clock),
      .en       (adv),
      .radicand (m2_p[MUL_HH]),
      .root     (root_hh)
   );

   // Stage F: the squared diagonal times (2L) squared, with the cross root added twice.
   always_comb begin
      f_in.valid = s3_ff[SQRT_LAT-1].valid;
      f_in.degen = s3_ff[SQRT_LAT-1].degen;
      f_in.len   = s3_ff[SQRT_LAT-1].len;
      f_in.flip  = s3_ff[SQRT_LAT-1].flip;
      f_in.q     = Q_W'(s3_ff[SQRT_LAT-1].qpart) + (Q_W'(root_hh) << 1);
   end

   ieft_isqrt u_isqrt_diag (
      .clock    (clock),
      .en       (adv),
      .radicand (PROD_W'(f_ff.q)),
      .root     (root_q)
   );

   // Divider seed: the length is floor(root / 2L). A quotient that would not fit
   // in 32 bits saturates, which the check against 2L shifted by 32 catches up front.
   always_comb begin
      d_seed.valid = s4_ff[SQRT_LAT-1].valid;
      d_seed.degen = s4_ff[SQRT_LAT-1].degen;
      d_seed.flip  = s4_ff[SQRT_LAT-1].flip;
      d_seed.dv    = {s4_ff[SQRT_LAT-1].len, 1'b0};
      d_seed.rem   = root_q[R2_W-1:0];
      d_seed.quo   = '0;
      d_seed.sat   = R2_W'({d_seed.dv, LEN_W'(0)}) <= d_seed.rem;
   end

   // Result: a degenerate pair never flips and reports a zero length.
   always_comb begin
      rsp_in.degenerate = d_ff[DIV_LAT-1].degen;
      rsp_in.needs_flip = d_ff[DIV_LAT-1].flip && !d_ff[DIV_LAT-1].degen;
      if (d_ff[DIV_LAT-1].degen) begin
         rsp_in.flipped_length = '0;
      end else if (d_ff[DIV_LAT-1].sat) begin
         rsp_in.flipped_length = '1;
      end else begin
         rsp_in.flipped_length = d_ff[DIV_LAT-1].quo;
      end
   end

   // All stage registers. Only the valid bits see reset; data holds when stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid   <= 1'b0;
         b_ff.valid   <= 1'b0;
         c_ff.valid   <= 1'b0;
         f_ff.valid   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MUL_LAT; i++) begin
            r1_ff[i].valid <= 1'b0;
            r2_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i < SQRT_LAT; i++) begin
            s3_ff[i].valid <= 1'b0;
            s4_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i < DIV_LAT; i++) d_ff[i].valid <= 1'b0;
      end else if (adv) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;

         r1_ff[0].valid <= c_ff.valid;
         r1_ff[0].degen <= c_ff.degen;
         r1_ff[0].len   <= c_ff.len;
         r1_ff[0].n0neg <= c_ff.n0neg;
         r1_ff[0].n1neg <= c_ff.n1neg;
         r2_ff[0]       <= r2_in;
         for (int i = 1; i < MUL_LAT; i++) begin
            r1_ff[i] <= r1_ff[i-1];
            r2_ff[i] <= r2_ff[i-1];
         end

         s3_ff[0] <= s3_in;
         for (int i = 1; i < SQRT_LAT; i++) s3_ff[i] <= s3_ff[i-1];

         f_ff <= f_in;

         s4_ff[0].valid <= f_ff.valid;
         s4_ff[0].degen <= f_ff.degen;
         s4_ff[0].len   <= f_ff.len;
         s4_ff[0].flip  <= f_ff.flip;
         for (int i = 1; i < SQRT_LAT; i++) s4_ff[i] <= s4_ff[i-1];

         d_ff[0] <= div_step(d_seed, LEN_W - 1);
         for (int i = 1; i < DIV_LAT; i++) d_ff[i] <= div_step(d_ff[i-1], LEN_W - 1 - i);

         rsp_valid_ff <= d_ff[DIV_LAT-1].valid;
         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/ieft_mul.sv =====
module ieft_mul (
   input  logic                        clock,
   input  logic                        en,
   input  logic [ieft_pkg::MUL_W-1:0]  a,
   input  logic [ieft_pkg::MUL_W-1:0]  b,
   output logic [ieft_pkg::PROD_W-1:0] p
);
   import ieft_pkg::*;

   localparam int PP_W   = 2 * LIMB_W;
   localparam int COLS   = 2 * LIMBS - 1;
   localparam int COL_W  = PP_W + $clog2(LIMBS) + 1;
   // Columns three limbs apart do not overlap, so each group is plain wiring.
   localparam int GROUPS = 3;

   logic [PP_W-1:0]   pp_ff [LIMBS*LIMBS];
   logic [COL_W-1:0]  col_in [COLS];
   logic [COL_W-1:0]  col_ff [COLS];
   logic [PROD_W-1:0] grp [GROUPS];
   logic [PROD_W-1:0] low_ff, high_ff, p_ff;

   always_comb begin
      for (int k = 0; k < COLS; k++) col_in[k] = '0;
      for (int i = 0; i < LIMBS; i++) begin
         for (int j = 0; j < LIMBS; j++) begin
            col_in[i+j] = col_in[i+j] + COL_W'(pp_ff[i*LIMBS+j]);
         end
      end
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) grp[g] = '0;
      for (int k = 0; k < COLS; k++) begin
         grp[k % GROUPS] = grp[k % GROUPS] | (PROD_W'(col_ff[k]) << (k * LIMB_W));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LIMBS; i++) begin
            for (int j = 0; j < LIMBS; j++) begin
               pp_ff[i*LIMBS+j] <= PP_W'(a[i*LIMB_W +: LIMB_W]) * PP_W'(b[j*LIMB_W +: LIMB_W]);
            end
         end
         col_ff  <= col_in;
         low_ff  <= grp[0] + grp[1];
         high_ff <= grp[2];
         p_ff    <= low_ff + high_ff;
      end
   end

   assign p = p_ff;

endmodule

// ===== sv/ieft_isqrt.sv =====
module ieft_isqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [ieft_pkg::PROD_W-1:0] radicand,
   output logic [ieft_pkg::ROOT_W-1:0] root
);
   import ieft_pkg::*;

   localparam int REM_W = ROOT_W + 3;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [PROD_W-1:0] x;
   } sq_type;

   // One restoring step: bring down two radicand bits and try a one bit.
   function automatic sq_type sq_step(input sq_type s);
      sq_type           r;
      logic [REM_W-1:0] cur;
      logic [REM_W-1:0] trial;
      cur   = {s.rem[REM_W-3:0], s.x[PROD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      r.x   = {s.x[PROD_W-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = cur - trial;
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = cur;
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   sq_type seed;
   sq_type st_ff [SQRT_LAT];

   always_comb begin
      seed.rem  = '0;
      seed.root = '0;
      seed.x    = radicand;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= sq_step(seed);
         for (int j = 1; j < SQRT_LAT; j++) st_ff[j] <= sq_step(st_ff[j-1]);
      end
   end

   assign root = st_ff[SQRT_LAT-1].root;

endmodule

// ===== sv/ieft_checker.sv =====
`include "intrinsic_edge_flip_test_top_defines.svh"

module ieft_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ieft_pkg::rsp_type rsp_data
);

   // Reset empties the result register.
   `IEFT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // With no result waiting the block must take a transfer.
   `IEFT_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "input not ready while empty")

   // A degenerate pair is never flipped.
   `IEFT_ASSERT(a_degen_no_flip, clock, reset, rsp_valid |-> !(rsp_data.needs_flip && rsp_data.degenerate), "degenerate pair flipped")

   // A degenerate pair reports a zero diagonal.
   `IEFT_ASSERT(a_degen_zero_len, clock, reset, (rsp_valid && rsp_data.degenerate) |-> (rsp_data.flipped_length == '0), "degenerate length not zero")

   // A stalled result holds.
   `IEFT_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "stalled result changed")

endmodule

bind intrinsic_edge_flip_test_top ieft_checker u_ieft_checker (.*);
